>>> src/ipac_pkg.sv
// ----------------------------------------------------------------------------
// ipac_pkg: shared types and constants of the infusion pump alarm controller
// Codes for operations, commands, phases, alarm levels and configuration
// registers, and the command and status bundles between control and datapath.
// ----------------------------------------------------------------------------
package ipac_pkg;

  localparam int OP_BITS        = 3;
  localparam int VALUE_BITS     = 16;
  localparam int CMD_BITS       = 3;
  localparam int CMD_VALUE_BITS = 16;
  localparam int TOL_BITS       = 7;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int IN_TDATA_BITS  = 24;
  localparam int OUT_TDATA_BITS = 24;
  localparam int MAX_CHAIN      = 3;

  localparam logic [OP_BITS-1:0] OP_TICK          = 3'd0;
  localparam logic [OP_BITS-1:0] OP_FLOW_ORDER    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_FLOW_SAMPLE   = 3'd2;
  localparam logic [OP_BITS-1:0] OP_BAG_EMPTY     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_NURSE_CONFIRM = 3'd4;

  localparam logic [CMD_BITS-1:0] CMD_ADJUST   = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_STOP     = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LOW      = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_MEDIUM   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_CRITICAL = 3'd4;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_DEVIATION_DELAY   = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BAG_STOP_DELAY    = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TOLERANCE_PERCENT = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] DEVIATION_DELAY_RESET = 16'd5;
  localparam logic [CFG_DATA_BITS-1:0] BAG_STOP_DELAY_RESET  = 16'd60;
  localparam logic [TOL_BITS-1:0]      TOLERANCE_RESET       = 7'd10;
  localparam logic [TOL_BITS-1:0]      PERCENT_SCALE         = 7'd100;

  typedef enum logic [1:0] {
    PH_STOPPED    = 2'd0,
    PH_INFUSING   = 2'd1,
    PH_CORRECTING = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    AL_NONE     = 2'd0,
    AL_LOW      = 2'd1,
    AL_MEDIUM   = 2'd2,
    AL_CRITICAL = 2'd3
  } alarm_t;

  typedef struct packed {
    logic capture;
    logic prep;
    logic apply;
    logic step;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic op_known;
    logic chain_go;
    logic step_again;
    logic out_free;
  } dp_status_t;

endpackage

>>> src/ipac_datapath.sv
// ----------------------------------------------------------------------------
// ipac_datapath: pump state, timer and command register
// Holds configuration, the captured item, the deviation products, the pump and
// alarm state with its countdown, and the output register.
// ----------------------------------------------------------------------------
module ipac_datapath #(
  parameter int FLOW_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ipac_pkg::dp_cmd_t                    cmd,
  output ipac_pkg::dp_status_t                 status,
  input  logic [ipac_pkg::IN_TDATA_BITS-1:0]   s_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [ipac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ipac_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ipac_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
  output logic                                 m_tlast
);

  localparam int F  = FLOW_BITS;
  localparam int T  = TIMER_BITS;
  localparam int P  = FLOW_BITS + ipac_pkg::TOL_BITS;
  localparam int CW = (TIMER_BITS > ipac_pkg::CFG_DATA_BITS) ? TIMER_BITS
                                                              : ipac_pkg::CFG_DATA_BITS;
  localparam logic [T-1:0] TMAX = {T{1'b1}};

  typedef struct packed {
    ipac_pkg::phase_t phase;
    logic [F-1:0]     target;
    logic             bag_empty;
    ipac_pkg::alarm_t alarm;
    logic             low_sent;
    logic             stop_done;
    logic [T-1:0]     countdown;
    logic             armed;
    logic [T-1:0]     hold;
    logic [T-1:0]     since;
    logic [T-1:0]     dev_time;
  } st_t;

  logic [T-1:0]                           dev_delay;
  logic [T-1:0]                           bag_delay;
  logic [ipac_pkg::TOL_BITS-1:0]          tol;
  logic [ipac_pkg::OP_BITS-1:0]           op;
  logic [ipac_pkg::VALUE_BITS-1:0]        val;
  logic [P-1:0]                           prod_dev;
  logic [P-1:0]                           prod_tol;
  st_t                                    st;
  st_t                                    st_step;
  st_t                                    st_apply;
  st_t                                    st_next;
  logic                                   out_valid;
  logic [ipac_pkg::CMD_BITS-1:0]          out_cmd;
  logic [ipac_pkg::CMD_VALUE_BITS-1:0]    out_val;
  logic                                   out_last;
  logic [ipac_pkg::CMD_BITS-1:0]          emit_cmd;
  logic [ipac_pkg::CMD_VALUE_BITS-1:0]    emit_val;
  logic [F-1:0]                           flow_v;
  logic [F-1:0]                           diff;
  logic [P-1:0]                           diff_w;
  logic [P-1:0]                           tol_w;
  logic [P-1:0]                           tgt_w;
  logic [P-1:0]                           prod_dev_next;
  logic [P-1:0]                           prod_tol_next;
  logic                                   dev;
  logic [CW-1:0]                          cfg_wide;
  logic [T-1:0]                           cfg_timer;

  function automatic st_t arm(st_t s, logic [T-1:0] ticks);
    st_t r;
    r           = s;
    r.armed     = 1'b1;
    r.hold      = ticks;
    r.countdown = ticks;
    return r;
  endfunction

  function automatic st_t disarm(st_t s);
    st_t r;
    r           = s;
    r.armed     = 1'b0;
    r.hold      = '0;
    r.countdown = '0;
    return r;
  endfunction

  function automatic st_t shorten(st_t s, logic [T-1:0] e);
    st_t r;
    r = s;
    if (s.armed) begin
      r = arm(s, (s.hold > e) ? s.hold - e : '0);
    end else begin
      r.countdown = s.hold;
    end
    return r;
  endfunction

  function automatic logic waiting_stop(st_t s);
    return s.bag_empty && s.low_sent && !s.stop_done;
  endfunction

  function automatic ipac_pkg::phase_t run_phase(st_t s);
    return (s.target != '0) ? ipac_pkg::PH_INFUSING : ipac_pkg::PH_STOPPED;
  endfunction

  function automatic st_t do_step(st_t s, logic [T-1:0] dd, logic [T-1:0] bd);
    st_t r;
    r = s;
    if (s.bag_empty && !s.low_sent) begin
      r.low_sent = 1'b1;
      r          = arm(r, bd);
      r.since    = '0;
    end else if (waiting_stop(s)) begin
      r.phase     = ipac_pkg::PH_STOPPED;
      r.target    = '0;
      r.stop_done = 1'b1;
      r           = disarm(r);
      r.since     = '0;
    end else if (s.phase == ipac_pkg::PH_CORRECTING && s.alarm == ipac_pkg::AL_NONE) begin
      r.alarm    = ipac_pkg::AL_MEDIUM;
      r.dev_time = '0;
      r          = arm(r, dd);
      r.since    = '0;
    end else if (s.phase == ipac_pkg::PH_CORRECTING && s.alarm == ipac_pkg::AL_MEDIUM) begin
      r.phase    = ipac_pkg::PH_STOPPED;
      r.target   = '0;
      r.alarm    = ipac_pkg::AL_CRITICAL;
      r.dev_time = '0;
      r          = arm(r, '0);
      r.since    = '0;
    end else if (s.phase == ipac_pkg::PH_STOPPED && s.target == '0) begin
      if (s.alarm != ipac_pkg::AL_CRITICAL) begin
        r.alarm = ipac_pkg::AL_NONE;
      end
      r.dev_time = '0;
      r          = disarm(r);
      r.since    = '0;
    end else if (s.phase == ipac_pkg::PH_INFUSING && s.target != '0) begin
      r.bag_empty = 1'b0;
      r.dev_time  = '0;
      r           = disarm(r);
      r.since     = '0;
    end else begin
      r.countdown = s.hold;
    end
    return r;
  endfunction

  function automatic st_t do_sample(st_t s, logic d, logic [T-1:0] dd);
    st_t          r;
    logic [T:0]   sum;
    logic [T-1:0] dt;
    r   = s;
    sum = {1'b0, s.dev_time} + {1'b0, s.since};
    dt  = sum[T] ? TMAX : sum[T-1:0];
    if (waiting_stop(s)) begin
      r       = shorten(s, s.since);
      r.since = '0;
    end else if (s.alarm == ipac_pkg::AL_CRITICAL) begin
      r.countdown = s.hold;
      r.since     = '0;
    end else if (s.alarm == ipac_pkg::AL_MEDIUM) begin
      if (d) begin
        r       = shorten(s, s.since);
        r.phase = ipac_pkg::PH_CORRECTING;
      end else begin
        r.phase    = run_phase(s);
        r.alarm    = ipac_pkg::AL_NONE;
        r.dev_time = '0;
        r          = disarm(r);
      end
      r.since = '0;
    end else if (s.alarm != ipac_pkg::AL_NONE) begin
      r.countdown = s.hold;
    end else begin
      if (d && s.phase == ipac_pkg::PH_CORRECTING) begin
        r.dev_time = dt;
        r          = arm(r, (dd > dt) ? dd - dt : '0);
      end else if (d) begin
        r.phase    = ipac_pkg::PH_CORRECTING;
        r.dev_time = '0;
        r          = arm(r, dd);
      end else begin
        r.phase    = run_phase(s);
        r.dev_time = '0;
        r          = disarm(r);
      end
      r.since = '0;
    end
    return r;
  endfunction

  function automatic st_t do_apply(st_t s, logic [ipac_pkg::OP_BITS-1:0] o,
                                   logic [ipac_pkg::VALUE_BITS-1:0] v, logic d,
                                   logic [T-1:0] dd);
    st_t          r;
    logic [F-1:0] fv;
    logic         one;
    r   = s;
    fv  = F'(v);
    one = (v == ipac_pkg::VALUE_BITS'(1));
    case (o)
      ipac_pkg::OP_TICK: begin
        if (s.since != TMAX) begin
          r.since = s.since + T'(1);
        end
        if (s.armed && s.countdown != '0) begin
          r.countdown = s.countdown - T'(1);
        end
      end
      ipac_pkg::OP_FLOW_ORDER: begin
        r.target   = fv;
        r.phase    = (fv != '0) ? ipac_pkg::PH_INFUSING : ipac_pkg::PH_STOPPED;
        r.alarm    = ipac_pkg::AL_NONE;
        r.dev_time = '0;
        r.since    = '0;
        r          = arm(r, '0);
      end
      ipac_pkg::OP_FLOW_SAMPLE: begin
        r = do_sample(s, d, dd);
      end
      ipac_pkg::OP_BAG_EMPTY: begin
        if (one) begin
          r.bag_empty = 1'b1;
          r.alarm     = ipac_pkg::AL_LOW;
          r.low_sent  = 1'b0;
          r.stop_done = 1'b0;
          r.since     = '0;
          r           = arm(r, '0);
        end else begin
          r.countdown = s.hold;
        end
      end
      ipac_pkg::OP_NURSE_CONFIRM: begin
        if (!one) begin
          r.countdown = s.hold;
        end else begin
          if (s.alarm == ipac_pkg::AL_CRITICAL && s.phase == ipac_pkg::PH_STOPPED) begin
            r.target = '0;
            r        = disarm(r);
          end else if (waiting_stop(s)) begin
            r = shorten(r, s.since);
          end else begin
            r = disarm(r);
          end
          r.alarm    = ipac_pkg::AL_NONE;
          r.dev_time = '0;
          r.since    = '0;
        end
      end
      default: begin
        r = s;
      end
    endcase
    return r;
  endfunction

  // deviation products, registered before the compare
  always_comb begin
    flow_v        = F'(val);
    diff          = (flow_v > st.target) ? flow_v - st.target : st.target - flow_v;
    diff_w        = P'(diff);
    tol_w         = P'(tol);
    tgt_w         = P'(st.target);
    prod_dev_next = diff_w * P'(ipac_pkg::PERCENT_SCALE);
    prod_tol_next = tol_w * tgt_w;
    dev           = (st.target != '0) && (prod_dev > prod_tol);
  end

  always_comb begin
    emit_cmd = ipac_pkg::CMD_ADJUST;
    emit_val = '0;
    if (st.bag_empty && !st.low_sent) begin
      emit_cmd = ipac_pkg::CMD_LOW;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(1);
    end else if (waiting_stop(st)) begin
      emit_cmd = ipac_pkg::CMD_STOP;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(1);
    end else if (st.phase == ipac_pkg::PH_INFUSING && st.target != '0 &&
                 st.alarm == ipac_pkg::AL_NONE && !st.bag_empty) begin
      emit_cmd = ipac_pkg::CMD_ADJUST;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(st.target);
    end else if (st.phase == ipac_pkg::PH_CORRECTING && st.alarm == ipac_pkg::AL_NONE) begin
      emit_cmd = ipac_pkg::CMD_MEDIUM;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(1);
    end else if (st.phase == ipac_pkg::PH_CORRECTING && st.alarm == ipac_pkg::AL_MEDIUM) begin
      emit_cmd = ipac_pkg::CMD_CRITICAL;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(1);
    end else if (st.phase == ipac_pkg::PH_STOPPED && st.target == '0) begin
      emit_cmd = ipac_pkg::CMD_STOP;
      emit_val = ipac_pkg::CMD_VALUE_BITS'(1);
    end
  end

  always_comb begin
    st_step  = do_step(st, dev_delay, bag_delay);
    st_apply = do_apply(st, op, val, dev, dev_delay);
    if (cmd.apply) begin
      st_next = st_apply;
    end else if (cmd.step) begin
      st_next = st_step;
    end else begin
      st_next = st;
    end
  end

  // saturate a written delay to the timer range
  always_comb begin
    cfg_wide  = CW'(cfg_data);
    cfg_timer = (cfg_wide > CW'(TMAX)) ? TMAX : T'(cfg_wide);
  end

  always_comb begin
    status.op_known   = op inside {ipac_pkg::OP_TICK, ipac_pkg::OP_FLOW_ORDER,
                                   ipac_pkg::OP_FLOW_SAMPLE, ipac_pkg::OP_BAG_EMPTY,
                                   ipac_pkg::OP_NURSE_CONFIRM};
    status.chain_go   = st.armed && (st.countdown == '0);
    status.step_again = st_step.armed && (st_step.countdown == '0);
    status.out_free   = !out_valid || m_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_delay    <= T'(ipac_pkg::DEVIATION_DELAY_RESET);
      bag_delay    <= T'(ipac_pkg::BAG_STOP_DELAY_RESET);
      tol          <= ipac_pkg::TOLERANCE_RESET;
      st.phase     <= ipac_pkg::PH_STOPPED;
      st.target    <= '0;
      st.bag_empty <= 1'b0;
      st.alarm     <= ipac_pkg::AL_NONE;
      st.low_sent  <= 1'b0;
      st.stop_done <= 1'b0;
      st.countdown <= '0;
      st.armed     <= 1'b0;
      st.hold      <= '0;
      st.since     <= '0;
      st.dev_time  <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          ipac_pkg::CFG_DEVIATION_DELAY:   dev_delay <= cfg_timer;
          ipac_pkg::CFG_BAG_STOP_DELAY:    bag_delay <= cfg_timer;
          ipac_pkg::CFG_TOLERANCE_PERCENT: tol <= cfg_data[ipac_pkg::TOL_BITS-1:0];
          default: ;
        endcase
      end
      st <= st_next;
      if (cmd.step) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op  <= s_tdata[ipac_pkg::OP_BITS-1:0];
      val <= s_tdata[ipac_pkg::OP_BITS +: ipac_pkg::VALUE_BITS];
    end
    if (cmd.prep) begin
      prod_dev <= prod_dev_next;
      prod_tol <= prod_tol_next;
    end
    if (cmd.step) begin
      out_cmd  <= emit_cmd;
      out_val  <= emit_val;
      out_last <= cmd.last;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {{(ipac_pkg::OUT_TDATA_BITS - ipac_pkg::CMD_BITS
                       - ipac_pkg::CMD_VALUE_BITS){1'b0}}, out_val, out_cmd};

endmodule

>>> src/ipac_control.sv
// ----------------------------------------------------------------------------
// ipac_control: item sequencer
// Steps each item through capture, product, apply and the command chain, and
// counts the commands emitted for the item.
// ----------------------------------------------------------------------------
module ipac_control (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  ipac_pkg::dp_status_t status,
  output ipac_pkg::dp_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_APPLY,
    S_CHAIN
  } state_t;

  localparam logic [1:0] LAST_COUNT = 2'(ipac_pkg::MAX_CHAIN - 1);

  state_t     state;
  logic [1:0] count;
  logic       emit_last;

  assign s_tready  = (state == S_IDLE);
  assign emit_last = (count == LAST_COUNT) || !status.step_again;

  always_comb begin
    cmd.capture = (state == S_IDLE) && s_tvalid;
    cmd.prep    = (state == S_PREP);
    cmd.apply   = (state == S_APPLY);
    cmd.step    = (state == S_CHAIN) && status.chain_go && status.out_free;
    cmd.last    = emit_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          count <= '0;
          state <= status.op_known ? S_CHAIN : S_IDLE;
        end
        S_CHAIN: begin
          if (!status.chain_go) begin
            state <= S_IDLE;
          end else if (status.out_free) begin
            count <= count + 2'd1;
            if (emit_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

>>> src/infusion_pump_alarm_controller.sv
// ----------------------------------------------------------------------------
// infusion_pump_alarm_controller: infusion pump alarm and flow controller
// Takes ticks, flow orders, flow samples, bag-empty and nurse-confirm events
// and issues flow, stop and alarm commands from a countdown timer.
// ----------------------------------------------------------------------------
// One item is handled at a time by a four-state sequencer: an item whose
// operation code is unknown goes back to idle after the apply state; any
// other item then enters the command chain and causes no command or 1 to 3
// commands, each one waiting while the output side stalls. The input is ready
// again as soon as the last command sits in the output register. Delays are
// counted in tick items, not clock cycles.
module infusion_pump_alarm_controller #(
  parameter int FLOW_BITS  = 16,
  parameter int TIMER_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ipac_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [2:0] operation, [18:3] value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ipac_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [2:0] command, [18:3] command_value
  output logic                                 m_tlast,
  input  logic                                 cfg_wr_en,
  input  logic [ipac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [ipac_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  ipac_pkg::dp_cmd_t    cmd;
  ipac_pkg::dp_status_t status;

  ipac_control u_control (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  ipac_datapath #(
    .FLOW_BITS  (FLOW_BITS),
    .TIMER_BITS (TIMER_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the infusion pump alarm controller
// Drives ticks, flow orders, flow samples, bag and confirm events with random
// gaps and output stalls, predicts every command with a cycle-free model of
// the alarm and timer logic, and compares each command transfer in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [ipac_pkg::CMD_BITS-1:0]       cmd;
    logic [ipac_pkg::CMD_VALUE_BITS-1:0] value;
    logic                                last;
  } pump_command_t;

  class pump_command_scoreboard;
    logic [15:0]      dev_delay;
    logic [15:0]      bag_delay;
    logic [6:0]       tol;
    ipac_pkg::phase_t ph;
    ipac_pkg::alarm_t alarm;
    logic [15:0]      target;
    logic [15:0]      measured;
    bit               bag_empty;
    bit               low_sent;
    bit               stop_done;
    bit               armed;
    logic [15:0]      countdown;
    logic [15:0]      hold;
    logic [15:0]      since_mark;
    logic [15:0]      dev_time;
    int               errors;
    pump_command_t    pending_commands[$];

    function new();
      dev_delay  = ipac_pkg::DEVIATION_DELAY_RESET;
      bag_delay  = ipac_pkg::BAG_STOP_DELAY_RESET;
      tol        = ipac_pkg::TOLERANCE_RESET;
      ph         = ipac_pkg::PH_STOPPED;
      alarm      = ipac_pkg::AL_NONE;
      target     = '0;
      measured   = '0;
      bag_empty  = 1'b0;
      low_sent   = 1'b0;
      stop_done  = 1'b0;
      armed      = 1'b0;
      countdown  = '0;
      hold       = '0;
      since_mark = '0;
      dev_time   = '0;
      errors     = 0;
    endfunction

    function void set_register(logic [ipac_pkg::CFG_INDEX_BITS-1:0] idx,
                               logic [ipac_pkg::CFG_DATA_BITS-1:0] data);
      case (idx)
        ipac_pkg::CFG_DEVIATION_DELAY:   dev_delay = data;
        ipac_pkg::CFG_BAG_STOP_DELAY:    bag_delay = data;
        ipac_pkg::CFG_TOLERANCE_PERCENT: tol = data[ipac_pkg::TOL_BITS-1:0];
        default: ;
      endcase
    endfunction

    function void arm_timer(logic [15:0] ticks);
      armed     = 1'b1;
      hold      = ticks;
      countdown = ticks;
    endfunction

    function void disarm_timer();
      armed     = 1'b0;
      hold      = '0;
      countdown = '0;
    endfunction

    function void shorten_timer(logic [15:0] elapsed);
      if (armed) begin
        arm_timer(hold > elapsed ? hold - elapsed : 16'd0);
      end else begin
        countdown = hold;
      end
    endfunction

    function bit awaiting_stop();
      return bag_empty && low_sent && !stop_done;
    endfunction

    function void set_run_phase();
      if (target != 0) begin
        ph = ipac_pkg::PH_INFUSING;
      end else begin
        ph = ipac_pkg::PH_STOPPED;
      end
    endfunction

    function void next_command(output logic [ipac_pkg::CMD_BITS-1:0] c,
                               output logic [ipac_pkg::CMD_VALUE_BITS-1:0] v);
      c = ipac_pkg::CMD_ADJUST;
      v = '0;
      if (bag_empty && !low_sent) begin
        c = ipac_pkg::CMD_LOW;
        v = 16'd1;
      end else if (awaiting_stop()) begin
        c = ipac_pkg::CMD_STOP;
        v = 16'd1;
      end else if (ph == ipac_pkg::PH_INFUSING && target != 0 &&
                   alarm == ipac_pkg::AL_NONE && !bag_empty) begin
        c = ipac_pkg::CMD_ADJUST;
        v = target;
      end else if (ph == ipac_pkg::PH_CORRECTING && alarm == ipac_pkg::AL_NONE) begin
        c = ipac_pkg::CMD_MEDIUM;
        v = 16'd1;
      end else if (ph == ipac_pkg::PH_CORRECTING && alarm == ipac_pkg::AL_MEDIUM) begin
        c = ipac_pkg::CMD_CRITICAL;
        v = 16'd1;
      end else if (ph == ipac_pkg::PH_STOPPED && target == 0) begin
        c = ipac_pkg::CMD_STOP;
        v = 16'd1;
      end
    endfunction

    function void advance_state();
      if (bag_empty && !low_sent) begin
        low_sent = 1'b1;
        arm_timer(bag_delay);
      end else if (awaiting_stop()) begin
        ph        = ipac_pkg::PH_STOPPED;
        target    = '0;
        stop_done = 1'b1;
        disarm_timer();
      end else if (ph == ipac_pkg::PH_CORRECTING && alarm == ipac_pkg::AL_NONE) begin
        alarm    = ipac_pkg::AL_MEDIUM;
        dev_time = '0;
        arm_timer(dev_delay);
      end else if (ph == ipac_pkg::PH_CORRECTING && alarm == ipac_pkg::AL_MEDIUM) begin
        ph       = ipac_pkg::PH_STOPPED;
        target   = '0;
        alarm    = ipac_pkg::AL_CRITICAL;
        dev_time = '0;
        arm_timer(16'd0);
      end else if (ph == ipac_pkg::PH_STOPPED && target == 0) begin
        if (alarm != ipac_pkg::AL_CRITICAL) alarm = ipac_pkg::AL_NONE;
        dev_time = '0;
        disarm_timer();
      end else if (ph == ipac_pkg::PH_INFUSING && target != 0) begin
        bag_empty = 1'b0;
        dev_time  = '0;
        disarm_timer();
      end else begin
        countdown = hold;
        return;
      end
      since_mark = '0;
    endfunction

    function void take_sample(logic [15:0] v);
      logic [15:0] elapsed;
      logic [31:0] diff;
      logic [16:0] sum;
      bit          deviates;
      elapsed  = since_mark;
      deviates = 1'b0;
      measured = v;
      if (awaiting_stop()) begin
        shorten_timer(elapsed);
        since_mark = '0;
        return;
      end
      if (target != 0) begin
        diff     = (measured > target) ? 32'(measured) - 32'(target)
                                       : 32'(target) - 32'(measured);
        deviates = (diff * 32'd100) > (32'(tol) * 32'(target));
      end
      if (alarm == ipac_pkg::AL_CRITICAL) begin
        countdown  = hold;
        since_mark = '0;
        return;
      end
      if (alarm == ipac_pkg::AL_MEDIUM) begin
        if (deviates) begin
          shorten_timer(elapsed);
          ph         = ipac_pkg::PH_CORRECTING;
          since_mark = '0;
          return;
        end
        set_run_phase();
        alarm    = ipac_pkg::AL_NONE;
        dev_time = '0;
        disarm_timer();
        since_mark = '0;
        return;
      end
      if (alarm != ipac_pkg::AL_NONE) begin
        countdown = hold;
        return;
      end
      if (deviates && ph == ipac_pkg::PH_CORRECTING) begin
        sum      = {1'b0, dev_time} + {1'b0, elapsed};
        dev_time = sum[16] ? 16'hFFFF : sum[15:0];
        arm_timer(dev_delay > dev_time ? dev_delay - dev_time : 16'd0);
      end else if (deviates) begin
        ph       = ipac_pkg::PH_CORRECTING;
        dev_time = '0;
        arm_timer(dev_delay);
      end else begin
        set_run_phase();
        dev_time = '0;
        disarm_timer();
      end
      since_mark = '0;
    endfunction

    function void take_confirm(logic [15:0] v);
      logic [15:0] elapsed;
      elapsed = since_mark;
      if (v != 16'd1) begin
        countdown = hold;
        return;
      end
      if (alarm == ipac_pkg::AL_CRITICAL && ph == ipac_pkg::PH_STOPPED) begin
        target   = '0;
        alarm    = ipac_pkg::AL_NONE;
        dev_time = '0;
        disarm_timer();
      end else if (awaiting_stop()) begin
        alarm    = ipac_pkg::AL_NONE;
        dev_time = '0;
        shorten_timer(elapsed);
      end else begin
        alarm    = ipac_pkg::AL_NONE;
        dev_time = '0;
        disarm_timer();
      end
      since_mark = '0;
    endfunction

    function void note_event(logic [ipac_pkg::OP_BITS-1:0] op,
                             logic [ipac_pkg::VALUE_BITS-1:0] v);
      logic [ipac_pkg::CMD_BITS-1:0]       c;
      logic [ipac_pkg::CMD_VALUE_BITS-1:0] cv;
      pump_command_t                       item;
      int                                  n;
      case (op)
        ipac_pkg::OP_TICK: begin
          if (since_mark != 16'hFFFF) since_mark = since_mark + 16'd1;
          if (armed && countdown != 0) countdown = countdown - 16'd1;
        end
        ipac_pkg::OP_FLOW_ORDER: begin
          target = v;
          set_run_phase();
          alarm      = ipac_pkg::AL_NONE;
          dev_time   = '0;
          since_mark = '0;
          arm_timer(16'd0);
        end
        ipac_pkg::OP_FLOW_SAMPLE: take_sample(v);
        ipac_pkg::OP_BAG_EMPTY: begin
          if (v == 16'd1) begin
            bag_empty  = 1'b1;
            alarm      = ipac_pkg::AL_LOW;
            low_sent   = 1'b0;
            stop_done  = 1'b0;
            since_mark = '0;
            arm_timer(16'd0);
          end else begin
            countdown = hold;
          end
        end
        ipac_pkg::OP_NURSE_CONFIRM: take_confirm(v);
        default: return;
      endcase
      n = 0;
      while (n < ipac_pkg::MAX_CHAIN && armed && countdown == 0) begin
        next_command(c, cv);
        advance_state();
        n = n + 1;
        item.cmd   = c;
        item.value = cv;
        item.last  = !(n < ipac_pkg::MAX_CHAIN && armed && countdown == 0);
        pending_commands.push_back(item);
      end
    endfunction

    function void check_command(logic [ipac_pkg::CMD_BITS-1:0] c,
                                logic [ipac_pkg::CMD_VALUE_BITS-1:0] cv,
                                logic l);
      pump_command_t exp_cmd;
      if (pending_commands.size() == 0) begin
        $display("%0t: unexpected command: expected none, actual cmd %0d value %0d last %0d",
                 $time, c, cv, l);
        errors = errors + 1;
        return;
      end
      exp_cmd = pending_commands.pop_front();
      if (c !== exp_cmd.cmd) begin
        $display("%0t: command mismatch: expected %0d, actual %0d", $time, exp_cmd.cmd, c);
        errors = errors + 1;
      end
      if (cv !== exp_cmd.value) begin
        $display("%0t: command_value mismatch: expected %0d, actual %0d",
                 $time, exp_cmd.value, cv);
        errors = errors + 1;
      end
      if (l !== exp_cmd.last) begin
        $display("%0t: last mismatch: expected %0d, actual %0d", $time, exp_cmd.last, l);
        errors = errors + 1;
      end
    endfunction
  endclass

  logic                                  clk = 1'b0;
  logic                                  rst = 1'b1;
  logic                                  s_tvalid = 1'b0;
  logic                                  s_tready;
  logic [ipac_pkg::IN_TDATA_BITS-1:0]    s_tdata = '0;   // [2:0] operation, [18:3] value
  logic                                  m_tvalid;
  logic                                  m_tready = 1'b0;
  logic [ipac_pkg::OUT_TDATA_BITS-1:0]   m_tdata;        // [2:0] command, [18:3] command_value
  logic                                  m_tlast;
  logic                                  cfg_wr_en = 1'b0;
  logic [ipac_pkg::CFG_INDEX_BITS-1:0]   cfg_index = '0;
  logic [ipac_pkg::CFG_DATA_BITS-1:0]    cfg_data = '0;

  pump_command_scoreboard pump_model;
  bit                     send_gaps = 1'b1;
  bit                     stall_gaps = 1'b1;
  logic [15:0]            order_flow = '0;
  int unsigned            quiet_cycles = 0;

  infusion_pump_alarm_controller i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    m_tready <= !stall_gaps || ($urandom_range(0, 99) >= 37);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pump_model.check_command(m_tdata[2:0], m_tdata[18:3], m_tlast);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_register(logic [ipac_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [ipac_pkg::CFG_DATA_BITS-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    pump_model.set_register(idx, data);
    @(posedge clk);
  endtask

  task automatic program_registers(logic [15:0] dev, logic [15:0] bag, logic [6:0] tol);
    write_register(ipac_pkg::CFG_DEVIATION_DELAY, dev);
    write_register(ipac_pkg::CFG_BAG_STOP_DELAY, bag);
    write_register(ipac_pkg::CFG_TOLERANCE_PERCENT, {9'd0, tol});
  endtask

  task automatic send_event(logic [ipac_pkg::OP_BITS-1:0] op,
                            logic [ipac_pkg::VALUE_BITS-1:0] v);
    if (send_gaps) begin
      while ($urandom_range(0, 99) < 37) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'd0, v, op};
    do @(posedge clk); while (!s_tready);
    pump_model.note_event(op, v);
  endtask

  // hold input until every predicted command has been transferred
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pump_model.pending_commands.size() != 0) @(posedge clk);
  endtask

  task automatic settle_idle();
    hold_until_drained();
    repeat (8) @(posedge clk);
  endtask

  task automatic random_event(output bit counted);
    int unsigned                  pick;
    int unsigned                  span;
    logic [ipac_pkg::OP_BITS-1:0] op;
    logic [15:0]                  v;
    pick    = $urandom_range(0, 99);
    v       = 16'($urandom);
    counted = 1'b1;
    if (pick < 40) begin
      op = ipac_pkg::OP_TICK;
    end else if (pick < 65) begin
      op = ipac_pkg::OP_FLOW_SAMPLE;
      if ($urandom_range(0, 4) != 0) begin
        span = (32'(order_flow) * $urandom_range(0, 2 * pump_model.tol + 2)) / 100;
        if ($urandom_range(0, 1) != 0) begin
          v = (32'(order_flow) + span > 32'hFFFF) ? 16'hFFFF : 16'(order_flow + span);
        end else begin
          v = (32'(order_flow) > span) ? 16'(order_flow - span) : 16'd0;
        end
      end
    end else if (pick < 77) begin
      op = ipac_pkg::OP_FLOW_ORDER;
      if ($urandom_range(0, 7) == 0) v = 16'd0;
      else if ($urandom_range(0, 3) != 0) v = 16'($urandom_range(1, 2000));
      order_flow = v;
    end else if (pick < 86) begin
      op = ipac_pkg::OP_BAG_EMPTY;
      if ($urandom_range(0, 4) != 0) v = 16'd1;
    end else if (pick < 96) begin
      op = ipac_pkg::OP_NURSE_CONFIRM;
      if ($urandom_range(0, 4) != 0) v = 16'd1;
    end else begin
      op      = 3'($urandom_range(5, 7));
      counted = 1'b0;
    end
    send_event(op, v);
    if ($urandom_range(0, 39) == 0) hold_until_drained();
  endtask

  task automatic random_phase(int unsigned count);
    int unsigned done;
    bit          counted;
    done = 0;
    while (done < count) begin
      random_event(counted);
      if (counted) done = done + 1;
    end
  endtask

  initial begin
    pump_model = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default delays and tolerance, short bag stop so the stop shows up
    write_register(ipac_pkg::CFG_BAG_STOP_DELAY, 16'd2);
    send_event(ipac_pkg::OP_TICK, 16'hFFFF);
    send_event(3'd5, 16'h1234);
    send_event(3'd7, 16'hFFFF);
    send_event(ipac_pkg::OP_FLOW_ORDER, 16'd1000);
    send_event(ipac_pkg::OP_FLOW_SAMPLE, 16'd1100);
    send_event(ipac_pkg::OP_FLOW_SAMPLE, 16'd1101);
    repeat (10) send_event(ipac_pkg::OP_TICK, 16'd0);
    send_event(ipac_pkg::OP_NURSE_CONFIRM, 16'd2);
    send_event(ipac_pkg::OP_NURSE_CONFIRM, 16'd1);
    send_event(ipac_pkg::OP_BAG_EMPTY, 16'd0);
    send_event(ipac_pkg::OP_BAG_EMPTY, 16'd1);
    send_event(ipac_pkg::OP_TICK, 16'd0);
    send_event(ipac_pkg::OP_TICK, 16'd0);
    send_event(ipac_pkg::OP_FLOW_ORDER, 16'd1000);
    send_event(ipac_pkg::OP_FLOW_ORDER, 16'hFFFF);
    send_event(ipac_pkg::OP_FLOW_SAMPLE, 16'hFFFF);
    send_event(ipac_pkg::OP_FLOW_SAMPLE, 16'd0);
    send_event(ipac_pkg::OP_FLOW_ORDER, 16'd0);
    order_flow = 16'd0;

    settle_idle();
    program_registers(16'd1, 16'd1, 7'd0);
    random_phase(100);

    settle_idle();
    send_gaps  = 1'b0;
    stall_gaps = 1'b0;
    program_registers(16'd3, 16'd4, 7'd100);
    random_phase(100);

    settle_idle();
    send_gaps  = 1'b1;
    stall_gaps = 1'b1;
    program_registers(16'hFFFF, 16'hFFFF, 7'd50);
    random_phase(60);

    settle_idle();
    program_registers(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
                      7'($urandom_range(0, 30)));
    random_phase(240);

    hold_until_drained();
    repeat (20) @(posedge clk);
    if (pump_model.errors == 0 && pump_model.pending_commands.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

>>> files.f
src/ipac_pkg.sv
src/ipac_datapath.sv
src/ipac_control.sv
src/infusion_pump_alarm_controller.sv
tb/tb_top.sv
